>>> rtl/subpixel_point_splat_unit_macros.svh
// Assertion macros used by the checker file of the splat unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SUBPIXEL_POINT_SPLAT_UNIT_MACROS_SVH
`define SUBPIXEL_POINT_SPLAT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("splat unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("splat unit check failed");

`endif

>>> rtl/spsplat_pkg.sv
`default_nettype none

package spsplat_pkg;

    localparam int FRAC_BITS = 8;
    localparam int X_W       = 15;
    localparam int Y_W       = 14;
    localparam int GRP_W     = 3;
    localparam int PX_W      = 8;
    localparam int PY_W      = 7;
    localparam int CH_W      = 8;
    localparam int RGB_W     = 24;
    localparam int NUM_PAL   = 5;
    localparam int CFG_IDX_W = 3;

    // Weights are products of two (FRAC_BITS+1)-bit factors and reach exactly 1.0.
    localparam int WX_W   = FRAC_BITS + 1;
    localparam int W_W    = 2 * FRAC_BITS + 1;
    localparam int PROD_W = CH_W + W_W;

    localparam int RED_LSB   = 16;
    localparam int GREEN_LSB = 8;
    localparam int BLUE_LSB  = 0;

    localparam logic [WX_W-1:0] ONE_FX = WX_W'(1 << FRAC_BITS);
    // Adding one pixel and removing half a pixel keeps the sum non-negative.
    localparam logic [X_W:0] X_BIAS = (X_W + 1)'(1 << (FRAC_BITS - 1));
    localparam logic [Y_W:0] Y_BIAS = (Y_W + 1)'(1 << (FRAC_BITS - 1));

    localparam logic [RGB_W-1:0] PAL_RESET [NUM_PAL] = '{
        24'hFF1443, 24'h14C8FF, 24'hFFC814, 24'hFFFFFF, 24'h14FFB4
    };

    typedef logic [1:0] beat_idx_t;
    localparam beat_idx_t BEAT_TL = 2'd0;
    localparam beat_idx_t BEAT_TR = 2'd1;
    localparam beat_idx_t BEAT_BL = 2'd2;
    localparam beat_idx_t BEAT_BR = 2'd3;

    typedef struct packed {
        logic [PX_W-1:0]      base_x;
        logic [PY_W-1:0]      base_y;
        logic [FRAC_BITS-1:0] frac_x;
        logic [FRAC_BITS-1:0] frac_y;
        logic [RGB_W-1:0]     rgb;
    } point_t;

    typedef struct packed {
        logic [PX_W-1:0]  pix_x;
        logic [PY_W-1:0]  pix_y;
        logic [W_W-1:0]   weight;
        logic [RGB_W-1:0] rgb;
        logic             last;
    } beat_t;

endpackage

`default_nettype wire

>>> rtl/spsplat_front.sv
`default_nettype none

module spsplat_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spsplat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [spsplat_pkg::RGB_W-1:0]     cfg_data,
    input  wire logic                              point_valid,
    output logic                                   point_ready,
    input  wire logic [spsplat_pkg::X_W-1:0]       x_pos,
    input  wire logic [spsplat_pkg::Y_W-1:0]       y_pos,
    input  wire logic [spsplat_pkg::GRP_W-1:0]     color_group,
    output logic                                   pt_valid,
    input  wire logic                              pt_ready,
    output spsplat_pkg::point_t                    pt
);

    logic [spsplat_pkg::RGB_W-1:0] palette_reg [spsplat_pkg::NUM_PAL];
    logic                          pt_valid_reg;
    spsplat_pkg::point_t           pt_reg;
    spsplat_pkg::point_t           pt_next;
    logic [spsplat_pkg::X_W:0]     x_sum;
    logic [spsplat_pkg::Y_W:0]     y_sum;
    logic [spsplat_pkg::PX_W-1:0]  bx1;
    logic [spsplat_pkg::PY_W-1:0]  by1;
    logic                          take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spsplat_pkg::NUM_PAL; i++)
            begin
                palette_reg[i] <= spsplat_pkg::PAL_RESET[i];
            end
        end
        else if (cfg_valid && (cfg_index < spsplat_pkg::CFG_IDX_W'(spsplat_pkg::NUM_PAL)))
        begin
            palette_reg[cfg_index] <= cfg_data;
        end
    end

    // Base pixel plus one is the integer part of the biased position.
    assign x_sum = {1'b0, x_pos} + spsplat_pkg::X_BIAS;
    assign y_sum = {1'b0, y_pos} + spsplat_pkg::Y_BIAS;
    assign bx1   = x_sum[spsplat_pkg::FRAC_BITS +: spsplat_pkg::PX_W];
    assign by1   = y_sum[spsplat_pkg::FRAC_BITS +: spsplat_pkg::PY_W];

    always_comb
    begin
        pt_next.base_x = bx1 - spsplat_pkg::PX_W'(1);
        pt_next.base_y = by1 - spsplat_pkg::PY_W'(1);
        pt_next.frac_x = x_sum[spsplat_pkg::FRAC_BITS-1:0];
        pt_next.frac_y = y_sum[spsplat_pkg::FRAC_BITS-1:0];
        if (color_group < spsplat_pkg::GRP_W'(spsplat_pkg::NUM_PAL))
        begin
            pt_next.rgb = palette_reg[color_group];
        end
        else
        begin
            pt_next.rgb = '0;
        end
    end

    assign point_ready = !pt_valid_reg || pt_ready;
    assign take        = point_valid && point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
        end
        else if (point_ready)
        begin
            pt_valid_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pt_reg <= pt_next;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

endmodule

`default_nettype wire

>>> rtl/spsplat_beat.sv
`default_nettype none

module spsplat_beat (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pt_valid,
    output logic                    pt_ready,
    input  wire spsplat_pkg::point_t pt,
    output logic                    bt_valid,
    input  wire logic               bt_ready,
    output spsplat_pkg::beat_t      bt
);

    spsplat_pkg::beat_idx_t         idx_reg;
    logic                           bt_valid_reg;
    spsplat_pkg::beat_t             bt_reg;
    spsplat_pkg::beat_t             bt_next;
    logic                           load;
    logic                           dx;
    logic                           dy;
    logic [spsplat_pkg::WX_W-1:0]   wx;
    logic [spsplat_pkg::WX_W-1:0]   wy;
    logic [2*spsplat_pkg::WX_W-1:0] w_full;

    assign load     = pt_valid && (!bt_valid_reg || bt_ready);
    // The point is released once its bottom-right write has been issued.
    assign pt_ready = load && (idx_reg == spsplat_pkg::BEAT_BR);

    assign dx = idx_reg[0];
    assign dy = idx_reg[1];

    always_comb
    begin
        if (dx)
        begin
            wx = {1'b0, pt.frac_x};
        end
        else
        begin
            wx = spsplat_pkg::ONE_FX - {1'b0, pt.frac_x};
        end
        if (dy)
        begin
            wy = {1'b0, pt.frac_y};
        end
        else
        begin
            wy = spsplat_pkg::ONE_FX - {1'b0, pt.frac_y};
        end
        w_full         = wx * wy;
        bt_next.pix_x  = pt.base_x + spsplat_pkg::PX_W'(dx);
        bt_next.pix_y  = pt.base_y + spsplat_pkg::PY_W'(dy);
        bt_next.weight = w_full[spsplat_pkg::W_W-1:0];
        bt_next.rgb    = pt.rgb;
        bt_next.last   = (idx_reg == spsplat_pkg::BEAT_BR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= spsplat_pkg::BEAT_TL;
            bt_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg      <= idx_reg + 2'd1;
                bt_valid_reg <= 1'b1;
            end
            else if (bt_ready)
            begin
                bt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bt_reg <= bt_next;
        end
    end

    assign bt_valid = bt_valid_reg;
    assign bt       = bt_reg;

endmodule

`default_nettype wire

>>> rtl/spsplat_scale.sv
`default_nettype none

module spsplat_scale (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               bt_valid,
    output logic                                    bt_ready,
    input  wire spsplat_pkg::beat_t                 bt,
    output logic                                    pixel_valid,
    input  wire logic                               pixel_ready,
    output logic signed [spsplat_pkg::PX_W-1:0]     pixel_x,
    output logic signed [spsplat_pkg::PY_W-1:0]     pixel_y,
    output logic        [spsplat_pkg::CH_W-1:0]     red,
    output logic        [spsplat_pkg::CH_W-1:0]     green,
    output logic        [spsplat_pkg::CH_W-1:0]     blue,
    output logic                                    last
);

    logic                               out_valid_reg;
    logic signed [spsplat_pkg::PX_W-1:0] pixel_x_reg;
    logic signed [spsplat_pkg::PY_W-1:0] pixel_y_reg;
    logic [spsplat_pkg::CH_W-1:0]        red_reg;
    logic [spsplat_pkg::CH_W-1:0]        green_reg;
    logic [spsplat_pkg::CH_W-1:0]        blue_reg;
    logic                                last_reg;
    logic [spsplat_pkg::PROD_W-1:0]      prod_r;
    logic [spsplat_pkg::PROD_W-1:0]      prod_g;
    logic [spsplat_pkg::PROD_W-1:0]      prod_b;
    logic [spsplat_pkg::PROD_W-1:0]      weight_ext;
    logic                                load;

    assign weight_ext = spsplat_pkg::PROD_W'(bt.weight);
    assign prod_r = spsplat_pkg::PROD_W'(bt.rgb[spsplat_pkg::RED_LSB +: spsplat_pkg::CH_W])
                    * weight_ext;
    assign prod_g = spsplat_pkg::PROD_W'(bt.rgb[spsplat_pkg::GREEN_LSB +: spsplat_pkg::CH_W])
                    * weight_ext;
    assign prod_b = spsplat_pkg::PROD_W'(bt.rgb[spsplat_pkg::BLUE_LSB +: spsplat_pkg::CH_W])
                    * weight_ext;

    assign bt_ready = !out_valid_reg || pixel_ready;
    assign load     = bt_valid && bt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (bt_ready)
        begin
            out_valid_reg <= bt_valid;
        end
    end

    // Dropping the 2*FRAC_BITS weight fraction bits truncates each channel.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_x_reg <= $signed(bt.pix_x);
            pixel_y_reg <= $signed(bt.pix_y);
            red_reg     <= prod_r[2*spsplat_pkg::FRAC_BITS +: spsplat_pkg::CH_W];
            green_reg   <= prod_g[2*spsplat_pkg::FRAC_BITS +: spsplat_pkg::CH_W];
            blue_reg    <= prod_b[2*spsplat_pkg::FRAC_BITS +: spsplat_pkg::CH_W];
            last_reg    <= bt.last;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> rtl/subpixel_point_splat_unit.sv
// Area-weighted splat of one point onto four neighboring pixels.
//
// A point request (x_pos, y_pos with 8 fraction bits, color_group) enters on
// point_valid/point_ready. Each point produces four pixel write requests on
// pixel_valid/pixel_ready, in the order top-left, top-right, bottom-left,
// bottom-right; the fourth carries last. Channels are the palette color scaled
// by the pixel's overlap area and truncated; off-screen pixels are not clipped.
// The palette is written through cfg_valid/cfg_ready (always ready), with
// cfg_index 0 to 4 selecting a register; other indexes are ignored. Write the
// palette only while no point is in flight.
//
// The writes of a point follow each other without a gap when the receiver
// never stalls. The pipeline has three register stages: position split and
// palette lookup, write sequencing with the weight product, and channel
// scaling into the output register. The sequencing stage issues one write per
// cycle unless the output stalls, and the front stage can take the next point
// while the current one is still being written. When pixel_ready is low,
// every stage holds its contents and point_ready falls once the stages fill.
// Reset empties all stages and restores the palette defaults.
`default_nettype none

module subpixel_point_splat_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [spsplat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [spsplat_pkg::RGB_W-1:0]         cfg_data,
    input  wire logic                                  point_valid,
    output logic                                       point_ready,
    input  wire logic [spsplat_pkg::X_W-1:0]           x_pos,
    input  wire logic [spsplat_pkg::Y_W-1:0]           y_pos,
    input  wire logic [spsplat_pkg::GRP_W-1:0]         color_group,
    output logic                                       pixel_valid,
    input  wire logic                                  pixel_ready,
    output logic signed [spsplat_pkg::PX_W-1:0]        pixel_x,
    output logic signed [spsplat_pkg::PY_W-1:0]        pixel_y,
    output logic        [spsplat_pkg::CH_W-1:0]        red,
    output logic        [spsplat_pkg::CH_W-1:0]        green,
    output logic        [spsplat_pkg::CH_W-1:0]        blue,
    output logic                                       last
);

    // Split point held between the front stage and the write sequencer.
    logic                pt_valid;
    logic                pt_ready;
    spsplat_pkg::point_t pt;

    // One weighted write between the sequencer and the scaling stage.
    logic                bt_valid;
    logic                bt_ready;
    spsplat_pkg::beat_t  bt;

    spsplat_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .color_group (color_group),
        .pt_valid    (pt_valid),
        .pt_ready    (pt_ready),
        .pt          (pt)
    );

    spsplat_beat u_beat (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (pt_valid),
        .pt_ready (pt_ready),
        .pt       (pt),
        .bt_valid (bt_valid),
        .bt_ready (bt_ready),
        .bt       (bt)
    );

    spsplat_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .bt_valid    (bt_valid),
        .bt_ready    (bt_ready),
        .bt          (bt),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> rtl/spsplat_chk.sv
`default_nettype none

`include "subpixel_point_splat_unit_macros.svh"

module spsplat_chk (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  cfg_valid,
    input wire logic                                  cfg_ready,
    input wire logic                                  pixel_valid,
    input wire logic                                  pixel_ready,
    input wire logic signed [spsplat_pkg::PX_W-1:0]   pixel_x,
    input wire logic signed [spsplat_pkg::PY_W-1:0]   pixel_y,
    input wire logic        [spsplat_pkg::CH_W-1:0]   red,
    input wire logic        [spsplat_pkg::CH_W-1:0]   green,
    input wire logic        [spsplat_pkg::CH_W-1:0]   blue,
    input wire logic                                  last
);

    // A stalled write request keeps its payload.
    `SPS_ASSERT_NEXT(a_pixel_hold, pixel_valid && !pixel_ready, pixel_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(red) && $stable(green) && $stable(blue) && $stable(last))

    // The four writes of a point leave without a gap.
    `SPS_ASSERT_NEXT(a_point_burst, pixel_valid && pixel_ready && !last, pixel_valid)

    // Within a point the row stays or moves down by exactly one.
    `SPS_ASSERT_NEXT(a_row_step, pixel_valid && pixel_ready && !last, (pixel_y == $past(pixel_y)) || (pixel_y == $past(pixel_y) + spsplat_pkg::PY_W'(1)))

    // Palette writes are never held off.
    `SPS_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind subpixel_point_splat_unit spsplat_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last        (last)
);

`default_nettype wire
